@@ rtl/core/psc_pkg.sv @@
// Package for the path syntax checker: character codes, status codes,
// register indexes, per-path state type and the per-character update functions.
// Depends on nothing.
package psc_pkg;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_QUEST  = 8'h3F;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_DOT    = 8'h2E;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DRIVE   = 2'd1;
	localparam logic [1:0] ST_SEGMENT = 2'd2;
	localparam logic [1:0] ST_LENGTH  = 2'd3;

	localparam logic [1:0] CFG_PATH_LIMIT = 2'd0;
	localparam logic [1:0] CFG_NAME_LIMIT = 2'd1;
	localparam logic [1:0] CFG_EXT_LIMIT  = 2'd2;

	localparam logic [11:0] PATH_LIMIT_RST = 12'd260;
	localparam logic [7:0]  NAME_LIMIT_RST = 8'd255;
	localparam logic [7:0]  EXT_LIMIT_RST  = 8'd255;
	localparam logic [12:0] DRIVE_LEN      = 13'd3;

	typedef struct packed {
		logic [11:0] path_limit;
		logic [7:0]  name_limit;
		logic [7:0]  extension_limit;
	} lim_t;

	typedef struct packed {
		logic        error_seen;
		logic [1:0]  error_code;
		logic [12:0] total_length;
		logic [8:0]  name_length;
		logic [8:0]  extension_length;
		logic        in_extension;
		logic        segment_empty;
		logic        prev_dot;
	} seg_t;

	localparam seg_t SEG_RESET = '{
		error_seen: 1'b0, error_code: ST_OK, total_length: 13'd0,
		name_length: 9'd0, extension_length: 9'd0, in_extension: 1'b0,
		segment_empty: 1'b1, prev_dot: 1'b0
	};

	function automatic logic is_letter(logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_forbidden(logic [7:0] c);
		return c == CH_SLASH || c == CH_COLON || c == CH_STAR || c == CH_QUEST ||
			c == CH_LT || c == CH_GT || c == CH_PIPE;
	endfunction

	function automatic seg_t flag(seg_t st, logic [1:0] code);
		seg_t r;
		r = st;
		if (!st.error_seen) begin
			r.error_seen = 1'b1;
			r.error_code = code;
		end
		return r;
	endfunction

	function automatic seg_t clear_seg(seg_t st);
		seg_t r;
		r = st;
		r.name_length = 9'd0;
		r.extension_length = 9'd0;
		r.in_extension = 1'b0;
		r.segment_empty = 1'b1;
		r.prev_dot = 1'b0;
		return r;
	endfunction

	// End of a segment; extra is set when a backslash follows
	function automatic seg_t close_seg(seg_t st, logic extra, logic [11:0] plimit);
		seg_t r;
		logic [12:0] sum;
		r = st;
		sum = st.total_length + 13'(st.name_length) + 13'(st.extension_length) +
			13'(st.in_extension) + 13'(extra);
		if (st.prev_dot) begin
			r = flag(r, ST_SEGMENT);
		end else begin
			r.total_length = sum;
			if (sum > {1'b0, plimit})
				r = flag(r, ST_LENGTH);
		end
		return r;
	endfunction

	function automatic seg_t seg_char(seg_t st, logic [7:0] c, logic last, lim_t lim);
		seg_t r;
		logic [8:0] nl;
		logic [8:0] el;
		r = st;
		nl = st.name_length + 9'd1;
		el = st.extension_length + 9'd1;
		if (!st.error_seen) begin
			if (c == CH_BSLASH) begin
				if (st.segment_empty || last) begin
					r = flag(r, ST_SEGMENT);
				end else begin
					r = close_seg(st, 1'b1, lim.path_limit);
					r = clear_seg(r);
				end
			end else if (c == CH_DOT) begin
				if (st.segment_empty || st.in_extension) begin
					r = flag(r, ST_SEGMENT);
				end else begin
					r.in_extension = 1'b1;
					r.prev_dot = 1'b1;
					r.segment_empty = 1'b0;
					if (last)
						r = close_seg(r, 1'b0, lim.path_limit);
				end
			end else if (is_forbidden(c)) begin
				r = flag(r, ST_SEGMENT);
			end else if (!st.in_extension) begin
				r.name_length = nl;
				if (nl > {1'b0, lim.name_limit}) begin
					r = flag(r, ST_SEGMENT);
				end else begin
					r.segment_empty = 1'b0;
					r.prev_dot = 1'b0;
					if (last)
						r = close_seg(r, 1'b0, lim.path_limit);
				end
			end else begin
				r.extension_length = el;
				if (el > {1'b0, lim.extension_limit}) begin
					r = flag(r, ST_SEGMENT);
				end else begin
					r.segment_empty = 1'b0;
					r.prev_dot = 1'b0;
					if (last)
						r = close_seg(r, 1'b0, lim.path_limit);
				end
			end
		end
		return r;
	endfunction

endpackage

@@ rtl/core/path_syntax_check.sv @@
// Top level of the path syntax checker: input register, per-character
// update logic and result register. Depends on psc_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one path character and the
//   last flag per item. Output channel (out_valid / out_stall) carries one
//   status item for each path, produced by the item marked last:
//   0 valid, 1 bad drive prefix, 2 bad segment, 3 too long.
//   Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) sets
//   the path, name and extension limits; cfg_ready is always high. Write the
//   limits only while no path is in flight.
//   An accepted item waits in the input register, then updates the path
//   state and, for a last item, the result register. Throughput: one
//   character per cycle while in_stall is low, set by the single update
//   stage between the input register and the state and result registers.
//   A stalled status holds in the result register; the input register keeps
//   moving characters that do not end a path, and in_stall rises only when a
//   last item waits behind a stalled status.
//   Reset clears the path state, the item valid flags and restores the limit
//   registers to 260, 255 and 255.
module path_syntax_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  path_char,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);
	import psc_pkg::*;

	typedef enum logic [1:0] {
		POS_FIRST  = 2'd0,
		POS_SECOND = 2'd1,
		POS_ROOT   = 2'd2,
		POS_BODY   = 2'd3
	} pos_t;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	pos_t       pos_q;
	pos_t       pos_d;
	logic [7:0] held_q;
	logic [7:0] held_d;
	seg_t       seg_q;
	seg_t       seg_d;
	seg_t       seg_a;
	lim_t       lim_q;
	logic       out_valid_q;
	logic [1:0] status_q;
	logic [1:0] status_d;
	logic       adv;
	logic       accept;

	assign adv       = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign status    = status_q;

	always_comb begin
		pos_d = pos_q;
		held_d = held_q;
		seg_d = seg_q;
		seg_a = seg_q;
		unique case (pos_q)
			POS_FIRST: begin
				held_d = char_s1;
				pos_d = POS_SECOND;
				if (last_s1)
					seg_d = seg_char(seg_q, char_s1, 1'b1, lim_q);
			end
			POS_SECOND: begin
				pos_d = POS_BODY;
				if (char_s1 == CH_COLON) begin
					if (!is_letter(held_q) || last_s1)
						seg_d = flag(seg_q, ST_DRIVE);
					else
						pos_d = POS_ROOT;
				end else begin
					seg_a = seg_char(seg_q, held_q, 1'b0, lim_q);
					seg_d = seg_char(seg_a, char_s1, last_s1, lim_q);
				end
			end
			POS_ROOT: begin
				pos_d = POS_BODY;
				if (char_s1 != CH_BSLASH) begin
					seg_d = flag(seg_q, ST_DRIVE);
				end else begin
					seg_a.total_length = DRIVE_LEN;
					seg_a = clear_seg(seg_a);
					if (last_s1)
						seg_a = close_seg(seg_a, 1'b0, lim_q.path_limit);
					seg_d = seg_a;
				end
			end
			POS_BODY: begin
				seg_d = seg_char(seg_q, char_s1, last_s1, lim_q);
			end
		endcase
		status_d = seg_d.error_seen ? seg_d.error_code : ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pos_q <= POS_FIRST;
			held_q <= 8'd0;
			seg_q <= SEG_RESET;
			lim_q <= '{path_limit: PATH_LIMIT_RST, name_limit: NAME_LIMIT_RST,
				extension_limit: EXT_LIMIT_RST};
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;

			if (adv) begin
				if (last_s1) begin
					pos_q <= POS_FIRST;
					held_q <= 8'd0;
					seg_q <= SEG_RESET;
				end else begin
					pos_q <= pos_d;
					held_q <= held_d;
					seg_q <= seg_d;
				end
			end

			if (adv && last_s1)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_PATH_LIMIT: lim_q.path_limit <= cfg_data;
					CFG_NAME_LIMIT: lim_q.name_limit <= cfg_data[7:0];
					CFG_EXT_LIMIT:  lim_q.extension_limit <= cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= path_char;
			last_s1 <= last;
		end
		if (adv && last_s1)
			status_q <= status_d;
	end

	a_result_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> out_valid_q)
		else $error("result missing after last item");

	a_path_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> pos_q == POS_FIRST && !seg_q.error_seen)
		else $error("path state not cleared after last item");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && last_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");

	a_root_clean: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q == POS_ROOT |-> !seg_q.error_seen)
		else $error("error recorded before drive root");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(status_q))
		else $error("stalled result changed");

endmodule

@@ sim/tb_path_syntax_check.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for path_syntax_check: directed paths, then random paths
// under several limit settings, checked against a built-in path state predictor.
// Depends on psc_pkg and path_syntax_check.
module tb_path_syntax_check;
	import psc_pkg::*;

	localparam int RANDOM_PER_PHASE = 84;
	localparam int N_DIRECTED = 24;
	localparam int N_PHASES = 6;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  path_char = 8'h00;
	logic        last = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_PATH_LIMIT;
	logic [11:0] cfg_data = 12'h000;

	path_syntax_check DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.path_char(path_char),
		.last(last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [11:0] lim_path = PATH_LIMIT_RST;
	logic [7:0]  lim_name = NAME_LIMIT_RST;
	logic [7:0]  lim_ext = EXT_LIMIT_RST;
	logic [1:0]  pos;
	logic [7:0]  first_ch;
	logic        err;
	logic [1:0]  err_code;
	logic [12:0] tot_len;
	logic [8:0]  nm_len;
	logic [8:0]  ext_len;
	logic        in_ext;
	logic        seg_empty;
	logic        prev_dot;

	logic [1:0] expected_status[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	string dir_text [N_DIRECTED] = '{
		"a", "C:\\", "C:", "1:\\a", "*:", "C:a", "\\a", "a\\\\b", "a\\", ".a",
		"a.b.c", "a.\\b", "a.", "/", ":", "*", "?", "<", ">", "|",
		"\377\001", "z:\\n.e\\x", "a", "aaaaaaaaa\\"
	};
	int dir_rep [N_DIRECTED] = '{
		1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
		1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
		1, 1, 256, 30
	};
	int dir_code [N_DIRECTED] = '{
		ST_OK, ST_OK, ST_DRIVE, ST_DRIVE, ST_DRIVE, ST_DRIVE, ST_SEGMENT, ST_SEGMENT,
		ST_SEGMENT, ST_SEGMENT, ST_SEGMENT, ST_SEGMENT, ST_SEGMENT, ST_SEGMENT,
		ST_SEGMENT, ST_SEGMENT, ST_SEGMENT, ST_SEGMENT, ST_SEGMENT, ST_SEGMENT,
		ST_OK, -1, ST_SEGMENT, ST_LENGTH
	};

	int lim_sets [N_PHASES][3] = '{
		'{1, 1, 1}, '{4095, 255, 255}, '{12, 4, 2},
		'{40, 8, 3}, '{4095, 1, 255}, '{100, 20, 20}
	};

	function automatic void raise_error(logic [1:0] code);
		if (!err) begin
			err = 1'b1;
			err_code = code;
		end
	endfunction

	function automatic void start_segment();
		nm_len = 9'd0;
		ext_len = 9'd0;
		in_ext = 1'b0;
		seg_empty = 1'b1;
		prev_dot = 1'b0;
	endfunction

	function automatic void reset_path_state();
		pos = 2'd0;
		first_ch = 8'h00;
		err = 1'b0;
		err_code = ST_OK;
		tot_len = 13'd0;
		start_segment();
	endfunction

	function automatic void end_segment(logic extra);
		if (prev_dot) begin
			raise_error(ST_SEGMENT);
			return;
		end
		tot_len = tot_len + 13'(nm_len) + 13'(ext_len) + 13'(in_ext) + 13'(extra);
		if (tot_len > {1'b0, lim_path})
			raise_error(ST_LENGTH);
	endfunction

	function automatic void segment_char(logic [7:0] c, logic fin);
		if (err)
			return;
		if (c == CH_BSLASH) begin
			if (seg_empty || fin) begin
				raise_error(ST_SEGMENT);
			end else begin
				end_segment(1'b1);
				start_segment();
			end
			return;
		end
		if (c == CH_DOT) begin
			if (seg_empty || in_ext) begin
				raise_error(ST_SEGMENT);
				return;
			end
			in_ext = 1'b1;
			prev_dot = 1'b1;
			seg_empty = 1'b0;
		end else if (c == CH_SLASH || c == CH_COLON || c == CH_STAR || c == CH_QUEST ||
				c == CH_LT || c == CH_GT || c == CH_PIPE) begin
			raise_error(ST_SEGMENT);
			return;
		end else begin
			if (!in_ext) begin
				nm_len = nm_len + 9'd1;
				if (nm_len > {1'b0, lim_name}) begin
					raise_error(ST_SEGMENT);
					return;
				end
			end else begin
				ext_len = ext_len + 9'd1;
				if (ext_len > {1'b0, lim_ext}) begin
					raise_error(ST_SEGMENT);
					return;
				end
			end
			seg_empty = 1'b0;
			prev_dot = 1'b0;
		end
		if (fin)
			end_segment(1'b0);
	endfunction

	function automatic logic [1:0] step_path_state(logic [7:0] c, logic fin);
		logic [1:0] st;
		case (pos)
			2'd0: begin
				first_ch = c;
				pos = 2'd1;
				if (fin)
					segment_char(c, 1'b1);
			end
			2'd1: begin
				pos = 2'd3;
				if (c == CH_COLON) begin
					if (!((first_ch >= 8'h41 && first_ch <= 8'h5A) ||
							(first_ch >= 8'h61 && first_ch <= 8'h7A)) || fin)
						raise_error(ST_DRIVE);
					else
						pos = 2'd2;
				end else begin
					segment_char(first_ch, 1'b0);
					segment_char(c, fin);
				end
			end
			2'd2: begin
				pos = 2'd3;
				if (c != CH_BSLASH) begin
					raise_error(ST_DRIVE);
				end else begin
					tot_len = DRIVE_LEN;
					start_segment();
					if (fin)
						end_segment(1'b0);
				end
			end
			default: segment_char(c, fin);
		endcase
		st = err ? err_code : ST_OK;
		if (fin)
			reset_path_state();
		return st;
	endfunction

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (c == CH_BSLASH || c == CH_DOT || c == CH_SLASH || c == CH_COLON ||
			c == CH_STAR || c == CH_QUEST || c == CH_LT || c == CH_GT || c == CH_PIPE);
		return c;
	endfunction

	function automatic logic [7:0] special_char();
		case ($urandom_range(8))
			0: return CH_BSLASH;
			1: return CH_DOT;
			2: return CH_SLASH;
			3: return CH_COLON;
			4: return CH_STAR;
			5: return CH_QUEST;
			6: return CH_LT;
			7: return CH_GT;
			default: return CH_PIPE;
		endcase
	endfunction

	task automatic send_char(input logic [7:0] c, input logic fin, input int typed);
		logic [1:0] st;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		path_char <= c;
		last <= fin;
		do
			@(posedge clk);
		while (in_stall);
		st = step_path_state(c, fin);
		if (fin)
			expected_status.push_back(typed >= 0 ? 2'(typed) : st);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [11:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_PATH_LIMIT: lim_path = data;
			CFG_NAME_LIMIT: lim_name = data[7:0];
			CFG_EXT_LIMIT: lim_ext = data[7:0];
			default: ;
		endcase
	endtask

	task automatic write_limits(input int p, input int n, input int e);
		write_reg(CFG_PATH_LIMIT, 12'(p));
		write_reg(CFG_NAME_LIMIT, 12'(n));
		write_reg(CFG_EXT_LIMIT, 12'(e));
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(input int quota);
		logic [7:0] path_buf[$];
		int sent;
		int nseg;
		int len;
		int s;
		int k;
		logic drive;
		sent = 0;
		while (sent < quota) begin
			path_buf.delete();
			if ($urandom_range(99) < 75) begin
				drive = 1'($urandom_range(1));
				if (drive) begin
					if ($urandom_range(9) == 0)
						path_buf.push_back(plain_char());
					else if ($urandom_range(1))
						path_buf.push_back(8'($urandom_range(8'h41, 8'h5A)));
					else
						path_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
					path_buf.push_back(CH_COLON);
					path_buf.push_back(CH_BSLASH);
				end
				nseg = $urandom_range(drive ? 0 : 1, 4);
				for (s = 0; s < nseg; s++) begin
					if (s != 0)
						path_buf.push_back(CH_BSLASH);
					len = ($urandom_range(19) == 0) ? $urandom_range(1, lim_name + 2) :
						$urandom_range(1, 6);
					for (k = 0; k < len; k++)
						path_buf.push_back(plain_char());
					if ($urandom_range(1)) begin
						path_buf.push_back(CH_DOT);
						len = ($urandom_range(19) == 0) ? $urandom_range(1, lim_ext + 2) :
							$urandom_range(1, 4);
						for (k = 0; k < len; k++)
							path_buf.push_back(plain_char());
					end
				end
				// corrupt one character or slip an extra one in
				if ($urandom_range(3) == 0) begin
					k = $urandom_range(path_buf.size() - 1);
					if ($urandom_range(1))
						path_buf[k] = special_char();
					else
						path_buf.insert(k, $urandom_range(1) ? special_char() : plain_char());
				end
			end else begin
				len = $urandom_range(1, 6);
				for (k = 0; k < len; k++)
					path_buf.push_back($urandom_range(1) ? special_char() :
						8'($urandom_range(1, 255)));
			end
			for (k = 0; k < path_buf.size(); k++)
				send_char(path_buf[k], k == path_buf.size() - 1, -1);
			sent += path_buf.size();
		end
	endtask

	always @(posedge clk)
		out_stall <= arst_n && ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		logic [1:0] exp_st;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_status.size() == 0) begin
				$error("status: none expected, got %0d", status);
				mismatches++;
			end else begin
				exp_st = expected_status.pop_front();
				if (status !== exp_st) begin
					$error("status: expected %0d, got %0d", exp_st, status);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("FAILURE");
		$finish;
	end

	initial begin
		int i;
		int r;
		int k;
		int p;
		reset_path_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 34;
		recv_stall_pct = 51;
		for (i = 0; i < N_DIRECTED; i++)
			for (r = 0; r < dir_rep[i]; r++)
				for (k = 0; k < dir_text[i].len(); k++)
					send_char(dir_text[i][k],
						r == dir_rep[i] - 1 && k == dir_text[i].len() - 1, dir_code[i]);

		for (p = 0; p < N_PHASES; p++) begin
			drain_results();
			if (p < 2) begin
				send_idle_pct = 34;
				recv_stall_pct = 51;
			end else if (p < 4) begin
				send_idle_pct = 51;
				recv_stall_pct = 34;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			write_limits(lim_sets[p][0], lim_sets[p][1], lim_sets[p][2]);
			run_random(RANDOM_PER_PHASE);
		end
		drain_results();

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
